FILE: src/bta_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bta_pkg
// Shared sizes, codes and types of the block table heap allocator.
// ============================================================================
package bta_pkg;

    localparam int NUM_BLOCKS  = 1024;
    // power of two
    localparam int BLOCK_BYTES = 4096;

    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int IDX_W       = $clog2(NUM_BLOCKS);
    localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
    localparam int NEED_W      = 33 - BLOCK_SHIFT;
    localparam int BLK_W       = 32 - BLOCK_SHIFT;
    localparam int ENT_W       = 3;

    localparam int ENT_TAKEN = 0;
    localparam int ENT_FIRST = 1;
    localparam int ENT_NEXT  = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [31:0]      base;
        logic [CNT_W-1:0] count;
    } bta_cfg_t;

endpackage

FILE: src/block_table_heap_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// block_table_heap_allocator
// First-fit heap allocator over a table of fixed-size blocks.
// ============================================================================
// Usage:
//   s_* carries requests: s_tuser is the command (allocate or free), s_tdata
//   holds size_bytes in the low word and address in the high word.
//   m_* returns one result per request: m_tdata is the allocated address
//   (zero on failure and on every free), m_tuser the status.
//   The APB port sets base_address (0x0) and block_count (0x4); write these
//   only while no request is in flight.
//   After reset the table is cleared one entry per cycle, and s_tready stays
//   low until that pass is done.
//   One request is in work at a time. An allocate first checks the size,
//   then reads table entries in a first-fit scan, then marks each block of
//   the run it found. A free checks the block index, then clears each
//   block of the released chain. The scan and release rate is set by the
//   single read port of the table memory.
//   A result waits in the output register while m_tready is low; the next
//   request is taken meanwhile but its result waits for the slot to empty.
// ============================================================================
module block_table_heap_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // size_bytes[31:0], address[63:32]
    input  logic        s_tuser,    // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // result_address[31:0]
    output logic [1:0]  m_tuser,    // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bta_pkg::*;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    logic [31:0]      base_reg;
    logic [10:0]      count_reg;
    logic [CNT_W-1:0] live_count;
    logic             wr_en;
    bta_cfg_t         cfg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= 11'd1024;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_BASE:  base_reg  <= pwdata;
                REG_COUNT: count_reg <= pwdata[10:0];
                default:   base_reg  <= base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BASE:  prdata = base_reg;
            REG_COUNT: prdata = 32'(count_reg);
            default:   prdata = '0;
        endcase
    end

    // counts above the table size saturate
    assign live_count = (32'(count_reg) > 32'(NUM_BLOCKS))
                      ? CNT_W'(NUM_BLOCKS) : CNT_W'(count_reg);

    assign cfg.base  = base_reg;
    assign cfg.count = live_count;

    bta_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: src/bta_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// bta_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/bta_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// bta_seq
// Sequencer: table clear, first-fit scan, run marking and chain release.
// ============================================================================
module bta_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  bta_pkg::bta_cfg_t cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [1:0]        m_tuser
);
    import bta_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACHK  = 3'd2;
    localparam logic [2:0] S_ASCAN = 3'd3;
    localparam logic [2:0] S_AMARK = 3'd4;
    localparam logic [2:0] S_FCHK  = 3'd5;
    localparam logic [2:0] S_FSCAN = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic              cmd_reg, cmd_next;
    logic [1:0]        st_reg, st_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_addr_reg, m_addr_next;
    logic [1:0]        m_status_reg, m_status_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;
    logic              issue;
    logic [32:0]       size_sum;
    logic [31:0]       addr_off;

    bta_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign issue    = rd_idx_reg < cfg.count;
    assign size_sum = {1'b0, s_tdata[31:0]} + 33'(BLOCK_BYTES - 1);
    assign addr_off = s_tdata[63:32] - cfg.base;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_status_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        ev_idx_next   = ev_idx_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        left_next     = left_reg;
        need_next     = need_reg;
        blk_next      = blk_reg;
        cmd_next      = cmd_reg;
        st_next       = st_reg;
        m_tvalid_next = m_tvalid_reg;
        m_addr_next   = m_addr_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = ev_idx_reg;
        ram_wdata     = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // scan states read one entry ahead of the one being evaluated
        if (state_reg == S_ASCAN || state_reg == S_FSCAN)
        begin
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                pend_next   = 1'b1;
                ev_idx_next = rd_idx_reg[IDX_W-1:0];
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    need_next  = NEED_W'(size_sum >> BLOCK_SHIFT);
                    blk_next   = BLK_W'(addr_off >> BLOCK_SHIFT);
                    state_next = (s_tuser == CMD_FREE) ? S_FCHK : S_ACHK;
                end
            end
            S_ACHK:
            begin
                rd_idx_next = '0;
                pend_next   = 1'b0;
                run_next    = '0;
                if (need_reg == '0 || 33'(need_reg) > 33'(cfg.count))
                begin
                    st_next    = ST_NOMEM;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_ASCAN;
                end
            end
            S_ASCAN:
            begin
                if (pend_reg)
                begin
                    if (ram_rdata[ENT_TAKEN])
                    begin
                        run_next = '0;
                    end
                    else if (run_reg + 1'b1 == CNT_W'(need_reg))
                    begin
                        start_next  = (run_reg == '0) ? ev_idx_reg : start_reg;
                        ev_idx_next = (run_reg == '0) ? ev_idx_reg : start_reg;
                        left_next   = CNT_W'(need_reg);
                        state_next  = S_AMARK;
                    end
                    else
                    begin
                        run_next = run_reg + 1'b1;
                        if (run_reg == '0)
                        begin
                            start_next = ev_idx_reg;
                        end
                    end
                end
                else if (!issue)
                begin
                    st_next    = ST_NOMEM;
                    state_next = S_RESP;
                end
            end
            S_AMARK:
            begin
                ram_we                = 1'b1;
                ram_waddr             = ev_idx_reg;
                ram_wdata[ENT_TAKEN]  = 1'b1;
                ram_wdata[ENT_FIRST]  = (ev_idx_reg == start_reg);
                ram_wdata[ENT_NEXT]   = (left_reg != CNT_W'(1));
                ev_idx_next           = ev_idx_reg + 1'b1;
                left_next             = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end
            end
            S_FCHK:
            begin
                pend_next   = 1'b0;
                rd_idx_next = CNT_W'(blk_reg);
                if (32'(blk_reg) >= 32'(cfg.count))
                begin
                    st_next    = ST_RANGE;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ev_idx_reg;
                    if (!ram_rdata[ENT_NEXT])
                    begin
                        st_next    = ST_OK;
                        state_next = S_RESP;
                    end
                end
                else if (!issue)
                begin
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = st_reg;
                    m_addr_next   = (cmd_reg == CMD_ALLOC && st_reg == ST_OK)
                                  ? cfg.base + (32'(start_reg) << BLOCK_SHIFT) : '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        ev_idx_reg   <= ev_idx_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        left_reg     <= left_next;
        need_reg     <= need_next;
        blk_reg      <= blk_next;
        cmd_reg      <= cmd_next;
        st_reg       <= st_next;
        m_addr_reg   <= m_addr_next;
        m_status_reg <= m_status_next;
    end

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !m_tvalid_reg)
        else $error("result presented during table clear");

    a_mark_writes_taken: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_AMARK |-> ram_we && ram_wdata[ENT_TAKEN])
        else $error("run marking without a taken write");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_status_reg != ST_OK |-> m_addr_reg == '0)
        else $error("failed request returned a nonzero address");

    a_run_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ASCAN |-> 33'(run_reg) < 33'(need_reg))
        else $error("free run counter reached the request size");

endmodule
